[rtl/tccr_pkg.sv]
// Shared types, constants and helpers of the text console character renderer.
// No dependencies; tccr_front, tccr_back and the top level import this package.
`default_nettype none

package tccr_pkg;

  localparam int MAX_COLUMNS      = 120;
  localparam int MAX_ROWS         = 80;
  localparam int SCREEN_WIDTH     = 320;
  localparam int SCREEN_HEIGHT    = 480;
  localparam int MAX_GLYPH_HEIGHT = 16;
  localparam int MAX_GLYPH_WIDTH  = 8;

  localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_AW     = $clog2(CELLS);
  localparam int GLYPH_DEPTH = 4096;
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
  localparam int QDEPTH      = 2;
  localparam int QPW         = $clog2(QDEPTH);
  localparam int CFG_DW      = 7;
  localparam int CFG_AW      = 2;

  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [2:0] WHITE   = 3'd7;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FONT  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_GLYPH_W = 2'd0,
    CFG_GLYPH_H = 2'd1,
    CFG_COLS    = 2'd2,
    CFG_ROWS    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BC_PRINT,
    BC_LF,
    BC_TAB,
    BC_ESC,
    BC_CR
  } byte_cls_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_BYTE,
    ST_PSETUP,
    ST_PDIV,
    ST_PCELL,
    ST_PCWAIT,
    ST_PGRD,
    ST_PGWAIT,
    ST_SCRD,
    ST_SCWR,
    ST_CLRROW,
    ST_EMIT
  } back_state_e;

  // clamped register values
  typedef struct packed {
    logic [3:0] gw;
    logic [4:0] gh;
    logic [6:0] cols;
    logic [6:0] rows;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    byte_cls_e   cls;
    logic [7:0]  byte_v;
    logic        eow;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [11:0] fa;
  } item_t;

  typedef struct packed {
    logic init_busy;
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] colour;
  } cell_t;

  function automatic logic [15:0] pack565(input logic [4:0] r, input logic [5:0] g,
                                          input logic [4:0] b);
    return {r, g, b};
  endfunction

  function automatic logic [15:0] palette(input logic [2:0] c);
    logic [15:0] p;
    case (c)
      3'd0:    p = pack565(5'h00, 6'h00, 5'h00);
      3'd1:    p = pack565(5'h1f, 6'h00, 5'h00);
      3'd2:    p = pack565(5'h00, 6'h15, 5'h00);
      3'd3:    p = pack565(5'h0f, 6'h15, 5'h00);
      3'd4:    p = pack565(5'h00, 6'h00, 5'h1f);
      3'd5:    p = pack565(5'h1f, 6'h00, 5'h1f);
      3'd6:    p = pack565(5'h00, 6'h3f, 5'h1f);
      default: p = pack565(5'h1f, 6'h3f, 5'h1f);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/tccr_in_if.sv]
// Input channel: valid/ready handshake carrying one console/pixel/font word.
// Depends on nothing.
`default_nettype none

interface tccr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  byte_value;
  logic        end_of_write;
  logic [8:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [11:0] font_address;

  modport source (output valid, opcode, byte_value, end_of_write, pixel_x, pixel_y,
                  font_address, input ready);
  modport sink (input valid, opcode, byte_value, end_of_write, pixel_x, pixel_y,
                font_address, output ready);
endinterface

`default_nettype wire

[rtl/tccr_out_if.sv]
// Output channel: valid/ready handshake carrying one result word.
// Depends on nothing.
`default_nettype none

interface tccr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;
  logic [6:0]  cursor_column;
  logic [6:0]  cursor_row;

  modport source (output valid, pixel_color, cursor_column, cursor_row, input ready);
  modport sink (input valid, pixel_color, cursor_column, cursor_row, output ready);
endinterface

`default_nettype wire

[rtl/tccr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/tccr_front.sv]
// Front end: accepts input words, classifies opcode and byte, queues them.
// Depends on tccr_pkg and tccr_in_if.
`default_nettype none

module tccr_front import tccr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tccr_in_if.sink      in_ch,
  input  wire status_t status_i,
  output logic         q_valid_o,
  output item_t        q_item_o,
  input  wire logic    q_pop_i
);

  item_t          mem_q [QDEPTH];
  logic [QPW-1:0] wp_q, rp_q;
  logic [QPW:0]   cnt_q;
  logic           push;
  item_t          it;

  assign in_ch.ready = (cnt_q != (QPW+1)'(QDEPTH)) && !status_i.init_busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign q_item_o    = mem_q[rp_q];

  always_comb begin
    it.op     = op_e'(in_ch.opcode);
    it.byte_v = in_ch.byte_value;
    it.eow    = in_ch.end_of_write;
    it.x      = in_ch.pixel_x;
    it.y      = in_ch.pixel_y;
    it.fa     = in_ch.font_address;
    case (in_ch.byte_value)
      CH_LF:   it.cls = BC_LF;
      CH_TAB:  it.cls = BC_TAB;
      CH_ESC:  it.cls = BC_ESC;
      CH_CR:   it.cls = BC_CR;
      default: it.cls = BC_PRINT;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= it;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == QPW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
      end
      if (q_pop_i) begin
        rp_q <= (rp_q == QPW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPW+1)'(push) - (QPW+1)'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

[rtl/tccr_back.sv]
// Back end: sequencer for console bytes, scrolling, pixel reads and font loads.
// Depends on tccr_pkg, tccr_ram and tccr_out_if.
`default_nettype none

module tccr_back import tccr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  q_valid_i,
  input  wire item_t q_item_i,
  output logic       q_pop_o,
  output status_t    status_o,
  tccr_out_if.source out_ch
);

  back_state_e state_q, state_d;
  item_t       it_q, it_d;
  logic [6:0]  col_q, col_d, line_q, line_d;
  logic [2:0]  cur_q, cur_d;
  logic        esc_q, esc_d;
  logic [CELL_AW-1:0] ictr_q, ictr_d;
  logic [6:0]  sr_q, sr_d, sc_q, sc_d;
  logic [8:0]  qx_q, qx_d, qy_q, qy_d;
  logic [3:0]  rx_q, rx_d;
  logic [4:0]  ry_q, ry_d;
  logic [3:0]  dcnt_q, dcnt_d;
  logic        oob_q, oob_d;
  logic [GLYPH_AW-1:0] ga_q, ga_d;
  logic [2:0]  pcol_q, pcol_d;
  logic [15:0] px_q, px_d;
  logic        ovld_q, ovld_d;
  logic [15:0] opx_q;
  logic [6:0]  ocol_q, orow_q;
  logic        oload;

  logic               c_we;
  logic [CELL_AW-1:0] c_waddr, c_raddr;
  cell_t              c_wdata, c_rdata;
  logic               g_we;
  logic [7:0]         g_rdata;

  logic [6:0]  ccol, cline, ntab, nchr;
  logic [7:0]  cdiff;
  logic [5:0]  trial_x;
  logic [5:0]  trial_y;
  logic        ge_x, ge_y;
  logic [10:0] xlim, ylim;
  logic [12:0] gprod;
  logic        out_free;

  tccr_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  tccr_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (q_item_i.fa),
    .wdata_i (q_item_i.byte_v),
    .raddr_i (ga_q),
    .rdata_o (g_rdata)
  );

  assign status_o.init_busy = (state_q == ST_INIT);
  assign out_free           = !ovld_q || out_ch.ready;
  assign out_ch.valid       = ovld_q;
  assign out_ch.pixel_color = opx_q;
  assign out_ch.cursor_column = ocol_q;
  assign out_ch.cursor_row  = orow_q;

  // cursor clamped to the area in use
  assign ccol  = (col_q >= cfg_i.cols) ? cfg_i.cols - 7'd1 : col_q;
  assign cline = (line_q >= cfg_i.rows) ? cfg_i.rows - 7'd1 : line_q;
  assign ntab  = {ccol[6:3] + 4'd1, 3'b000};
  assign nchr  = ccol + 7'd1;
  assign cdiff = it_q.byte_v - CH_ZERO;

  assign trial_x = {1'b0, rx_q, qx_q[8]};
  assign trial_y = {ry_q, qy_q[8]};
  assign ge_x    = trial_x >= {2'b00, cfg_i.gw};
  assign ge_y    = trial_y >= {1'b0, cfg_i.gh};
  assign xlim    = 11'(cfg_i.cols) * 11'(cfg_i.gw);
  assign ylim    = 11'(cfg_i.rows) * 11'(cfg_i.gh);
  assign gprod   = 13'(c_rdata.ch) * 13'(cfg_i.gh) + 13'(ry_q);

  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    col_d   = col_q;
    line_d  = line_q;
    cur_d   = cur_q;
    esc_d   = esc_q;
    ictr_d  = ictr_q;
    sr_d    = sr_q;
    sc_d    = sc_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    dcnt_d  = dcnt_q;
    oob_d   = oob_q;
    ga_d    = ga_q;
    pcol_d  = pcol_q;
    px_d    = px_q;
    q_pop_o = 1'b0;
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = '{ch: 8'h00, colour: cur_q};
    c_raddr = '0;
    g_we    = 1'b0;
    oload   = 1'b0;

    case (state_q)
      ST_INIT: begin
        c_we    = 1'b1;
        c_waddr = ictr_q;
        c_wdata = '{ch: 8'h00, colour: WHITE};
        ictr_d  = ictr_q + 1'b1;
        if (ictr_q == CELL_AW'(CELLS-1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          it_d    = q_item_i;
          px_d    = '0;
          case (q_item_i.op)
            OP_BYTE:  state_d = ST_BYTE;
            OP_PIXEL: state_d = ST_PSETUP;
            OP_FONT: begin
              g_we    = 1'b1;
              state_d = ST_EMIT;
            end
            default:  state_d = ST_EMIT;
          endcase
        end
      end

      ST_BYTE: begin
        col_d   = ccol;
        line_d  = cline;
        state_d = ST_EMIT;
        sr_d    = 7'd1;
        sc_d    = '0;
        if (esc_q) begin
          cur_d = (cdiff < 8'd8) ? cdiff[2:0] : WHITE;
          esc_d = 1'b0;
        end else begin
          case (it_q.cls)
            BC_LF, BC_TAB, BC_PRINT: begin
              if (it_q.cls == BC_PRINT) begin
                c_we    = 1'b1;
                c_waddr = CELL_AW'(cline) * CELL_AW'(MAX_COLUMNS) + CELL_AW'(ccol);
                c_wdata = '{ch: it_q.byte_v, colour: cur_q};
              end
              if ((it_q.cls == BC_TAB) && (ntab < cfg_i.cols)) begin
                col_d = ntab;
              end else if ((it_q.cls == BC_PRINT) && (nchr < cfg_i.cols)) begin
                col_d = nchr;
              end else begin
                // new line, scrolling when already on the last row
                col_d = '0;
                if (cline + 7'd1 < cfg_i.rows) begin
                  line_d = cline + 7'd1;
                end else if (cfg_i.rows == 7'd1) begin
                  state_d = ST_CLRROW;
                end else begin
                  state_d = ST_SCRD;
                end
              end
            end
            BC_ESC: begin
              if (!it_q.eow) begin
                esc_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCRD: begin
        c_raddr = CELL_AW'(sr_q) * CELL_AW'(MAX_COLUMNS) + CELL_AW'(sc_q);
        state_d = ST_SCWR;
      end

      ST_SCWR: begin
        c_we    = 1'b1;
        c_waddr = CELL_AW'(sr_q - 7'd1) * CELL_AW'(MAX_COLUMNS) + CELL_AW'(sc_q);
        c_wdata = c_rdata;
        state_d = ST_SCRD;
        if (sc_q == cfg_i.cols - 7'd1) begin
          sc_d = '0;
          sr_d = sr_q + 7'd1;
          if (sr_q == cfg_i.rows - 7'd1) begin
            state_d = ST_CLRROW;
          end
        end else begin
          sc_d = sc_q + 7'd1;
        end
      end

      ST_CLRROW: begin
        c_we    = 1'b1;
        c_waddr = CELL_AW'(cfg_i.rows - 7'd1) * CELL_AW'(MAX_COLUMNS) + CELL_AW'(sc_q);
        c_wdata = '{ch: 8'h00, colour: cur_q};
        sc_d    = sc_q + 7'd1;
        if (sc_q == cfg_i.cols - 7'd1) begin
          state_d = ST_EMIT;
        end
      end

      ST_PSETUP: begin
        oob_d  = (it_q.x >= 9'(SCREEN_WIDTH)) || (it_q.y >= 9'(SCREEN_HEIGHT))
              || (11'(it_q.x) >= xlim) || (11'(it_q.y) >= ylim);
        qx_d   = it_q.x;
        qy_d   = it_q.y;
        rx_d   = '0;
        ry_d   = '0;
        dcnt_d = '0;
        state_d = ST_PDIV;
      end

      // one restoring-division step per cycle on both coordinates
      ST_PDIV: begin
        rx_d   = ge_x ? 4'(trial_x - {2'b00, cfg_i.gw}) : trial_x[3:0];
        ry_d   = ge_y ? 5'(trial_y - {1'b0, cfg_i.gh}) : trial_y[4:0];
        qx_d   = {qx_q[7:0], ge_x};
        qy_d   = {qy_q[7:0], ge_y};
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd8) begin
          state_d = oob_q ? ST_EMIT : ST_PCELL;
        end
      end

      ST_PCELL: begin
        c_raddr = CELL_AW'(qy_q[6:0]) * CELL_AW'(MAX_COLUMNS) + CELL_AW'(qx_q[6:0]);
        state_d = ST_PCWAIT;
      end

      ST_PCWAIT: begin
        ga_d    = gprod[GLYPH_AW-1:0];
        pcol_d  = c_rdata.colour;
        state_d = ST_PGRD;
      end

      ST_PGRD: begin
        state_d = ST_PGWAIT;
      end

      ST_PGWAIT: begin
        px_d    = g_rdata[3'd7 - rx_q[2:0]] ? palette(pcol_q) : 16'h0000;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          oload   = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    ovld_d = oload ? 1'b1 : (ovld_q && !out_ch.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      col_q   <= '0;
      line_q  <= '0;
      cur_q   <= WHITE;
      esc_q   <= 1'b0;
      ictr_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      line_q  <= line_d;
      cur_q   <= cur_d;
      esc_q   <= esc_d;
      ictr_q  <= ictr_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    sr_q   <= sr_d;
    sc_q   <= sc_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    dcnt_q <= dcnt_d;
    oob_q  <= oob_d;
    ga_q   <= ga_d;
    pcol_q <= pcol_d;
    px_q   <= px_d;
    if (oload) begin
      opx_q  <= px_q;
      ocol_q <= col_q;
      orow_q <= line_q;
    end
  end

endmodule

`default_nettype wire

[rtl/text_console_char_renderer.sv]
// Top level of the text console character renderer: configuration registers,
// front end and back end. Depends on tccr_pkg, tccr_in_if, tccr_out_if, tccr_front, tccr_back.
//
// Text-mode console with a 120x80 cell store (character plus 3-bit colour), a
// 4096-byte font store and a cursor. After reset the cell store is cleared by a
// sweep during which no input word is accepted (configuration writes are). Each
// word gives exactly one result: the pixel colour (zero for non-pixel opcodes)
// and the cursor after the word. All words go through the single back-end
// sequencer; a pixel read runs a 9-step division of x and y by the glyph size,
// then a cell store read and a font store read. A byte that moves below the last
// row scrolls the used area through the one-read/one-write cell store port. A
// two-word queue and an output register decouple the input and output sides. The
// user must write configuration only while idle; the block does not enforce it.
`default_nettype none

module text_console_char_renderer import tccr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_AW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  tccr_in_if.sink                in_ch,
  tccr_out_if.source             out_ch
);

  logic [3:0] gw_q;
  logic [4:0] gh_q;
  logic [6:0] cols_q, rows_q;
  cfg_t       cfg;
  status_t    status;
  logic       q_valid, q_pop;
  item_t      q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q   <= 4'd8;
      gh_q   <= 5'd16;
      cols_q <= 7'd40;
      rows_q <= 7'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GLYPH_W: gw_q   <= cfg_data_i[3:0];
        CFG_GLYPH_H: gh_q   <= cfg_data_i[4:0];
        CFG_COLS:    cols_q <= cfg_data_i;
        CFG_ROWS:    rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero reads as one, large values saturate
  always_comb begin
    cfg.gw   = (gw_q == '0) ? 4'd1 : (gw_q > 4'(MAX_GLYPH_WIDTH)) ?
               4'(MAX_GLYPH_WIDTH) : gw_q;
    cfg.gh   = (gh_q == '0) ? 5'd1 : (gh_q > 5'(MAX_GLYPH_HEIGHT)) ?
               5'(MAX_GLYPH_HEIGHT) : gh_q;
    cfg.cols = (cols_q == '0) ? 7'd1 : (cols_q > 7'(MAX_COLUMNS)) ?
               7'(MAX_COLUMNS) : cols_q;
    cfg.rows = (rows_q == '0) ? 7'd1 : (rows_q > 7'(MAX_ROWS)) ?
               7'(MAX_ROWS) : rows_q;
  end

  tccr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .status_i  (status),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  tccr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .status_o  (status),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
